### sv/hgl_pkg.sv
// ----------------------------------------------------------------------------
// hgl_pkg
// Shared types and constants of the hex glyph line parser.
// ----------------------------------------------------------------------------
package hgl_pkg;

  localparam int unsigned CpW          = 21;
  localparam int unsigned CharW        = 8;
  localparam int unsigned ByteIdxW     = 5;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned GlyphWidthW  = 5;
  localparam int unsigned DefMaxGlyphBytes = 32;

  // Byte counts that make a valid glyph and the pixel widths they imply.
  localparam logic [7:0] BytesNarrow = 8'd16;
  localparam logic [7:0] BytesWide   = 8'd32;
  localparam logic [GlyphWidthW-1:0] PixNarrow = 5'd8;
  localparam logic [GlyphWidthW-1:0] PixWide   = 5'd16;

  // Characters with a meaning of their own.
  localparam logic [CharW-1:0] ChColon   = 8'h3A;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChVtab    = 8'h0B;
  localparam logic [CharW-1:0] ChFormFd  = 8'h0C;
  localparam logic [CharW-1:0] ChCr      = 8'h0D;
  localparam logic [CharW-1:0] ChNul     = 8'h00;

  // Outcome codes.
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StMissing = 2'd1;
  localparam logic [StatusW-1:0] StFormat  = 2'd2;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_SKIP,
    PH_BITMAP,
    PH_DRAIN
  } phase_e;

  // Classification of one character.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
    logic       is_colon;
    logic       is_newline;
    logic       is_term;
  } char_class_t;

  // One result item.
  typedef struct packed {
    logic                   has_byte;
    logic [7:0]             byte_value;
    logic [ByteIdxW-1:0]    byte_index;
    logic                   done_res;
    logic [StatusW-1:0]     status;
    logic [GlyphWidthW-1:0] glyph_width;
  } result_t;

endpackage

### sv/hex_glyph_line_parser.sv
// ----------------------------------------------------------------------------
// hex_glyph_line_parser
// Scans a hex font text stream for the line of one codepoint and emits its
// bitmap bytes, then a success, missing or format error outcome.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_stall_o   character_i, end_of_file_i
//   out      source     out_valid_o/out_stall_i has_byte_o, byte_value_o,
//                                               byte_index_o, done_res_o,
//                                               status_o, glyph_width_o
//   cfg      sink       cfg_wr_en_i             cfg_wr_data_i (target codepoint)
//
// One character is taken per cycle unless the input stalls. A transfer on the
// input lands in the input register; the line state machine then processes it
// and any result is written into the output register. The only stage between
// the two registers is the character decode plus one state update, so
// throughput is one character per cycle while the consumer does not stall.
// Reset clears the line state, the target codepoint and both valid flags; no
// clearing pass is needed. A stall on a valid output holds the output register
// and any waiting input character, and the input stall then rises at once.
module hex_glyph_line_parser
  import hgl_pkg::*;
#(
  parameter int unsigned MaxGlyphBytes = DefMaxGlyphBytes
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration.
  input  logic                   cfg_wr_en_i,
  input  logic [CpW-1:0]         cfg_wr_data_i,
  // Character input.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CharW-1:0]       character_i,
  input  logic                   end_of_file_i,
  // Result output.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   has_byte_o,
  output logic [7:0]             byte_value_o,
  output logic [ByteIdxW-1:0]    byte_index_o,
  output logic                   done_res_o,
  output logic [StatusW-1:0]     status_o,
  output logic [GlyphWidthW-1:0] glyph_width_o
);

  logic [CpW-1:0]   target_q;

  // Input register.
  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             eof_q;

  logic             out_ready;
  logic             adv;
  logic             res_valid;
  char_class_t      cls;
  result_t          res;
  result_t          res_out;

  // The buffered character is processed once the result register can take
  // whatever it produces. Characters that produce no result still advance.
  assign adv        = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_wr_en_i) begin
      target_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= character_i;
      eof_q  <= end_of_file_i;
    end
  end

  hgl_classify u_classify (
    .char_i  (char_q),
    .class_o (cls)
  );

  hgl_step #(
    .MaxGlyphBytes (MaxGlyphBytes)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .class_i     (cls),
    .eof_i       (eof_q),
    .target_i    (target_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hgl_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && res_valid),
    .res_i   (res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign has_byte_o    = res_out.has_byte;
  assign byte_value_o  = res_out.byte_value;
  assign byte_index_o  = res_out.byte_index;
  assign done_res_o    = res_out.done_res;
  assign status_o      = res_out.status;
  assign glyph_width_o = res_out.glyph_width;

endmodule

### sv/hgl_classify.sv
// ----------------------------------------------------------------------------
// hgl_classify
// Decodes one font character into hex digit value and character classes.
// ----------------------------------------------------------------------------
module hgl_classify
  import hgl_pkg::*;
(
  input  logic [CharW-1:0] char_i,
  output char_class_t      class_o
);

  logic       is_dec;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] dval;

  always_comb begin
    is_dec   = (char_i >= 8'h30) && (char_i <= 8'h39);
    is_upper = (char_i >= 8'h41) && (char_i <= 8'h46);
    is_lower = (char_i >= 8'h61) && (char_i <= 8'h66);
    if (is_dec) begin
      dval = char_i - 8'h30;
    end else if (is_upper) begin
      dval = char_i - 8'h37;
    end else if (is_lower) begin
      dval = char_i - 8'h57;
    end else begin
      dval = 8'h00;
    end
    class_o.is_hex     = is_dec | is_upper | is_lower;
    class_o.digit      = dval[3:0];
    class_o.is_colon   = (char_i == ChColon);
    class_o.is_newline = (char_i == ChNewline);
    class_o.is_term    = (char_i == ChSpace) || (char_i == ChTab) ||
                         (char_i == ChNewline) || (char_i == ChVtab) ||
                         (char_i == ChFormFd) || (char_i == ChCr) ||
                         (char_i == ChNul);
  end

endmodule

### sv/hgl_step.sv
// ----------------------------------------------------------------------------
// hgl_step
// Line parser state machine: holds the per-line state and forms the result
// of each processed character.
// ----------------------------------------------------------------------------
module hgl_step
  import hgl_pkg::*;
#(
  parameter int unsigned MaxGlyphBytes = DefMaxGlyphBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  char_class_t    class_i,
  input  logic           eof_i,
  input  logic [CpW-1:0] target_i,
  output logic           res_valid_o,
  output result_t        res_o
);

  localparam int unsigned CntW = $clog2(MaxGlyphBytes + 1);

  phase_e            phase_q, phase_d;
  logic [CpW-1:0]    acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic [3:0]        hi_q, hi_d;
  logic              pend_q, pend_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic              match;
  logic              full;
  logic [CpW-1:0]    acc_shift;
  logic              ovf_shift;
  logic [7:0]        cnt_ext;
  logic [7:0]        cnt_inc;
  result_t           res;

  // Outcome of a finished bitmap: status in the upper bits, width below.
  function automatic logic [StatusW+GlyphWidthW-1:0] finish(input logic pend,
                                                            input logic [7:0] cnt);
    logic [StatusW+GlyphWidthW-1:0] r;
    begin
      if (pend) begin
        r = {StFormat, 5'd0};
      end else if (cnt == BytesNarrow) begin
        r = {StOk, PixNarrow};
      end else if (cnt == BytesWide) begin
        r = {StOk, PixWide};
      end else begin
        r = {StFormat, 5'd0};
      end
      return r;
    end
  endfunction

  assign match     = !ovf_q && (acc_q == target_i);
  assign full      = (cnt_q >= CntW'(MaxGlyphBytes));
  assign acc_shift = {acc_q[CpW-5:0], class_i.digit};
  assign ovf_shift = ovf_q | (acc_q[CpW-1:CpW-4] != 4'd0);
  assign cnt_ext   = 8'(cnt_q);
  assign cnt_inc   = cnt_ext + 8'd1;

  // Result of the current character.
  always_comb begin
    res = '0;
    case (phase_q)
      PH_CODE: begin
        if (class_i.is_hex) begin
          if (eof_i) begin
            res.done_res = 1'b1;
            res.status   = (!ovf_shift && (acc_shift == target_i)) ? StFormat : StMissing;
          end
        end else if (match) begin
          if (class_i.is_colon) begin
            if (eof_i) begin
              res.done_res = 1'b1;
              {res.status, res.glyph_width} = finish(pend_q, cnt_ext);
            end
          end else begin
            res.done_res = 1'b1;
            res.status   = StFormat;
          end
        end else if (eof_i) begin
          res.done_res = 1'b1;
          res.status   = StMissing;
        end
      end
      PH_SKIP: begin
        if (eof_i) begin
          res.done_res = 1'b1;
          res.status   = StMissing;
        end
      end
      PH_BITMAP: begin
        if (class_i.is_hex) begin
          if (pend_q) begin
            if (full) begin
              res.done_res = 1'b1;
              res.status   = StFormat;
            end else begin
              res.has_byte   = 1'b1;
              res.byte_value = {hi_q, class_i.digit};
              res.byte_index = cnt_ext[ByteIdxW-1:0];
              if (eof_i) begin
                res.done_res = 1'b1;
                {res.status, res.glyph_width} = finish(1'b0, cnt_inc);
              end
            end
          end else if (eof_i) begin
            // A single digit left at the end of the file.
            res.done_res = 1'b1;
            res.status   = StFormat;
          end
        end else if (class_i.is_term) begin
          res.done_res = 1'b1;
          {res.status, res.glyph_width} = finish(pend_q, cnt_ext);
        end else begin
          res.done_res = 1'b1;
          res.status   = StFormat;
        end
      end
      default: begin
      end
    endcase
  end

  // Next line state.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    hi_d    = hi_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    if (eof_i || ((phase_q != PH_DRAIN) && !res.done_res && class_i.is_newline &&
                  ((phase_q == PH_SKIP) || ((phase_q == PH_CODE) && !match)))) begin
      // End of file or end of a skipped line starts a fresh line.
      phase_d = PH_CODE;
      acc_d   = '0;
      ovf_d   = 1'b0;
      hi_d    = '0;
      pend_d  = 1'b0;
      cnt_d   = '0;
    end else if (res.done_res) begin
      phase_d = PH_DRAIN;
    end else begin
      case (phase_q)
        PH_CODE: begin
          if (class_i.is_hex) begin
            acc_d = acc_shift;
            ovf_d = ovf_shift;
          end else if (match) begin
            phase_d = PH_BITMAP;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_BITMAP: begin
          if (pend_q) begin
            cnt_d  = cnt_q + CntW'(1);
            pend_d = 1'b0;
          end else begin
            hi_d   = class_i.digit;
            pend_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      hi_q    <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      hi_q    <= hi_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_valid_o = res.has_byte | res.done_res;
  assign res_o       = res;

endmodule

### sv/hgl_out_reg.sv
// ----------------------------------------------------------------------------
// hgl_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module hgl_out_reg
  import hgl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    stall_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
